// File: rtl/lts_pkg.sv
// Shared types and constants for the LIS length tails search block.
// Used by lts_ctrl, lts_dp and lis_length_tails_search; depends on nothing.
package lts_pkg;

   // Tails store depth and the widths that follow from it
   localparam int MAX_LEN    = 1024;
   localparam int ADDR_W     = $clog2(MAX_LEN);
   localparam int LEN_W      = $clog2(MAX_LEN + 1);
   localparam int VALUE_W    = 32;
   localparam int LIS_LEN_W  = 11;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAST_RD,
      ST_LAST_CMP,
      ST_SEARCH,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;      // latch the input transaction, clear on first
      logic rd_last;   // read the last tail, open the search window
      logic step;      // one binary search step on the returned tail
      logic append;    // write value after the last tail, grow length
      logic set_ovf;   // mark a dropped append
      logic publish;   // load the result register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic empty;     // no tails stored
      logic full;      // length at MAX_LEN
      logic above;     // value above the tail just read
      logic conv;      // search window closes on this step
      logic rsp_busy;  // result register holds an untaken transaction
   } status_type;

endpackage

// File: rtl/lts_ctrl.sv
// Controller state machine for the LIS length tails search block.
// Depends on lts_pkg; drives commands into lts_dp.
module lts_ctrl import lts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd,
   output state_type  state
);

   state_type state_ff, state_in;

   // Hold the current state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance through load, last-tail check, search and result
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LAST_RD;
            end
         end
         ST_LAST_RD: begin
            if (status.empty) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_LAST_CMP;
            end
         end
         ST_LAST_CMP: begin
            if (status.above || status.conv) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.conv) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!status.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Drive commands for the current state
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_LAST_RD: begin
            if (status.empty) begin
               cmd.append = 1'b1;
            end else begin
               cmd.rd_last = 1'b1;
            end
         end
         ST_LAST_CMP: begin
            if (status.above) begin
               cmd.append  = !status.full;
               cmd.set_ovf = status.full;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_SEARCH: begin
            cmd.step = 1'b1;
         end
         ST_DONE: begin
            cmd.publish = !status.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign state = state_ff;

endmodule

// File: rtl/lts_dp.sv
// Datapath for the LIS length tails search block: tails memory, search
// window, length and overflow state, and the result register. Uses lts_pkg.
module lts_dp import lts_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [VALUE_W-1:0]   req_value,
   input  logic                 req_first,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [LIS_LEN_W-1:0] rsp_lis_length,
   output logic                 rsp_overflow,
   input  cmd_type              cmd,
   output status_type           status
);

   logic [VALUE_W-1:0]   mem [MAX_LEN];
   logic [VALUE_W-1:0]   value_ff;
   logic [VALUE_W-1:0]   rdata_ff;
   logic [LEN_W-1:0]     length_ff, length_in;
   logic                 ovf_ff, ovf_in;
   logic [ADDR_W-1:0]    lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LIS_LEN_W-1:0] rsp_len_ff;
   logic                 rsp_ovf_ff;

   logic                 ge;
   logic [ADDR_W-1:0]    lo_nxt, hi_nxt, mid_nxt, last_addr;
   logic                 conv;
   logic                 wr_en, rd_en;
   logic [ADDR_W-1:0]    wr_addr, rd_addr;

   // Narrow the search window on the tail that just came back
   always_comb begin
      ge        = $signed(rdata_ff) >= $signed(value_ff);
      lo_nxt    = ge ? lo_ff : mid_ff + ADDR_W'(1);
      hi_nxt    = ge ? mid_ff : hi_ff;
      mid_nxt   = lo_nxt + ((hi_nxt - lo_nxt) >> 1);
      conv      = (lo_nxt == hi_nxt);
      last_addr = ADDR_W'(length_ff - LEN_W'(1));
   end

   // Select memory port addresses
   always_comb begin
      wr_en   = cmd.append || (cmd.step && conv);
      wr_addr = cmd.append ? ADDR_W'(length_ff) : lo_nxt;
      rd_en   = cmd.rd_last || (cmd.step && !conv);
      rd_addr = cmd.rd_last ? last_addr : mid_nxt;
   end

   // Tails memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Next values of length, overflow, window and result valid
   always_comb begin
      length_in    = length_ff;
      ovf_in       = ovf_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load && req_first) begin
         length_in = '0;
         ovf_in    = 1'b0;
      end
      if (cmd.append) begin
         length_in = length_ff + LEN_W'(1);
      end
      if (cmd.set_ovf) begin
         ovf_in = 1'b1;
      end
      if (cmd.rd_last) begin
         lo_in  = '0;
         hi_in  = last_addr;
         mid_in = last_addr;
      end
      if (cmd.step) begin
         lo_in  = lo_nxt;
         hi_in  = hi_nxt;
         mid_in = mid_nxt;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      if (cmd.load) begin
         value_ff <= req_value;
      end
      if (cmd.publish) begin
         rsp_len_ff <= LIS_LEN_W'(length_ff);
         rsp_ovf_ff <= ovf_ff;
      end
   end

   // Status back to the controller
   always_comb begin
      status.empty    = (length_ff == '0);
      status.full     = (length_ff == LEN_W'(MAX_LEN));
      status.above    = $signed(value_ff) > $signed(rdata_ff);
      status.conv     = conv;
      status.rsp_busy = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_lis_length = rsp_len_ff;
   assign rsp_overflow   = rsp_ovf_ff;

endmodule

// File: rtl/lis_length_tails_search.sv
// Top level of the LIS length tails search block.
// Joins lts_ctrl and lts_dp; uses lts_pkg.
//
// Streams signed 32-bit values on the req_ channel (req_value, req_first)
// and returns one transaction per input on the rsp_ channel: the length of
// the longest strictly increasing subsequence so far and a sticky overflow
// flag. req_first starts a new sequence before its value is taken.
// Both channels use valid/stall; a transaction moves when valid is high
// and stall is low.
// Sequence: an append into an empty store goes from the last-tail read state
// straight to the done state, which loads the result register; otherwise the
// last tail is read, then compared, and the binary search takes one memory
// read per step, its pace set by the single registered read port.
// One transaction is worked at a time; req_stall is low only when idle.
// The result register lets a new transaction enter while the previous
// result waits; a finished item holds in the controller while rsp_stall
// keeps the result register full.
// Reset clears the length, the overflow flag and the result valid; the
// tails memory is not cleared, as only entries below the length are read.
module lis_length_tails_search import lts_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [VALUE_W-1:0]   req_value,
   input  logic                 req_first,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [LIS_LEN_W-1:0] rsp_lis_length,
   output logic                 rsp_overflow
);

   cmd_type    cmd;
   status_type status;
   state_type  state;

   lts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd),
      .state     (state)
   );

   lts_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_value),
      .req_first      (req_first),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_lis_length (rsp_lis_length),
      .rsp_overflow   (rsp_overflow),
      .cmd            (cmd),
      .status         (status)
   );

   // An accepted transaction keeps the input stalled on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after accept");

   // Overflow is only reported with a full store
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> (rsp_lis_length == LIS_LEN_W'(MAX_LEN)))
      else $error("overflow reported below full length");

   // A result is published only from the done state
   a_publish_done: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (state == ST_DONE))
      else $error("result published outside done state");

   // The result register is never overwritten while it is stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !cmd.publish)
      else $error("result overwritten while stalled");

endmodule

// File: test/tb_lis_length_tails_search.sv
// Self-checking testbench for lis_length_tails_search: a directed table, short random
// sequences, then one long mostly increasing run that fills the tails store to MAX_LEN and offers appends past it.
// Depends on rtl/lts_pkg.sv and the RTL of the block; reads no files.
`timescale 1ns / 100ps

module tb_lis_length_tails_search import lts_pkg::*;;

   typedef struct packed {
      logic [LIS_LEN_W-1:0] len;
      logic                 ovf;
   } lis_result_type;

   typedef struct {
      logic [VALUE_W-1:0] value;
      bit                 first;
      bit                 typed;
      lis_result_type     exp;
   } lis_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [VALUE_W-1:0]   req_value;
   logic                 req_first;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [LIS_LEN_W-1:0] rsp_lis_length;
   logic                 rsp_overflow;

   // Predictor state: smallest tail per subsequence length
   logic signed [VALUE_W-1:0] tail_store [MAX_LEN];
   int unsigned               seq_len;
   bit                        drop_seen;

   lis_result_type pending_q [$];
   int unsigned    mismatch_count;
   bit             no_idle;
   bit             hold_long_req;

   lis_length_tails_search dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_first      (req_first),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_lis_length (rsp_lis_length),
      .rsp_overflow   (rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the tails store by one value and return the result it causes
   function automatic lis_result_type lis_after_value(input logic signed [VALUE_W-1:0] v,
                                                      input bit first);
      lis_result_type res;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      if (first) begin
         seq_len   = 0;
         drop_seen = 1'b0;
      end
      if (seq_len == 0 || v > tail_store[seq_len - 1]) begin
         // append, or drop it when the store is full
         if (seq_len < MAX_LEN) begin
            tail_store[seq_len] = v;
            seq_len++;
         end else begin
            drop_seen = 1'b1;
         end
      end else begin
         // replace the first tail that is >= v
         lo = 0;
         hi = seq_len - 1;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (tail_store[mid] >= v) hi = mid;
            else lo = mid + 1;
         end
         tail_store[lo] = v;
      end
      res.len = seq_len[LIS_LEN_W-1:0];
      res.ovf = drop_seen;
      return res;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   // Offer one transaction, wait for it to be taken, queue its expected result
   task automatic offer_value(input logic [VALUE_W-1:0] value, input bit first,
                              input bit typed, input lis_result_type typed_exp);
      int unsigned gap;
      lis_result_type predicted;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_first <= first;
      do @(posedge clock); while (req_stall);
      predicted = lis_after_value(value, first);
      pending_q.push_back(typed ? typed_exp : predicted);
   endtask

   // Drop valid and hold until every queued result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_q.size() != 0);
   endtask

   // Result side: random stall per transaction, one long hold on request
   initial begin
      int unsigned hold;
      lis_result_type want;
      do @(posedge clock); while (reset);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 3);
         if (hold_long_req) begin
            hold          = 80;
            hold_long_req = 1'b0;
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         if (pending_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected result length %0d overflow %0b",
                                    rsp_lis_length, rsp_overflow));
         end else begin
            want = pending_q.pop_front();
            if (rsp_lis_length !== want.len)
               flag_mismatch($sformatf("lis_length %0d, expected %0d",
                                       rsp_lis_length, want.len));
            if (rsp_overflow !== want.ovf)
               flag_mismatch($sformatf("overflow %0b, expected %0b",
                                       rsp_overflow, want.ovf));
         end
      end
   end

   // Stimulus: directed table, short random sequences, long run to overflow
   initial begin
      lis_row_type dir_rows [0:20];
      logic [VALUE_W-1:0] v;
      int          cur;
      int unsigned seq;
      int unsigned n;
      int unsigned run_len;
      int unsigned kind;
      int unsigned items_in_run;
      bit          f;

      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_value      = '0;
      req_first      = 1'b0;
      rsp_stall      = 1'b0;
      mismatch_count = 0;
      no_idle        = 1'b0;
      hold_long_req  = 1'b0;
      seq_len        = 0;
      drop_seen      = 1'b0;

      dir_rows = '{
         '{32'd5,        1'b0, 1'b1, '{11'd1, 1'b0}},  // no first flag after reset
         '{32'd5,        1'b0, 1'b1, '{11'd1, 1'b0}},  // equal value
         '{32'd7,        1'b0, 1'b1, '{11'd2, 1'b0}},
         '{32'd6,        1'b0, 1'b0, '{11'd0, 1'b0}},
         '{32'hFFFFFFFD, 1'b0, 1'b0, '{11'd0, 1'b0}},  // new minimum
         '{32'h7FFFFFFF, 1'b0, 1'b0, '{11'd0, 1'b0}},
         '{32'h7FFFFFFF, 1'b0, 1'b0, '{11'd0, 1'b0}},
         '{32'h80000000, 1'b0, 1'b0, '{11'd0, 1'b0}},
         '{32'h80000000, 1'b1, 1'b1, '{11'd1, 1'b0}},  // restart at most negative
         '{32'h80000000, 1'b0, 1'b1, '{11'd1, 1'b0}},
         '{32'h80000001, 1'b0, 1'b1, '{11'd2, 1'b0}},
         '{32'h00000000, 1'b0, 1'b0, '{11'd0, 1'b0}},
         '{32'hFFFFFFFF, 1'b0, 1'b0, '{11'd0, 1'b0}},
         '{32'h7FFFFFFF, 1'b1, 1'b1, '{11'd1, 1'b0}},  // restart at most positive
         '{32'h80000000, 1'b0, 1'b1, '{11'd1, 1'b0}},
         '{32'h00000000, 1'b0, 1'b1, '{11'd2, 1'b0}},
         '{32'h55555555, 1'b0, 1'b0, '{11'd0, 1'b0}},
         '{32'hAAAAAAAA, 1'b0, 1'b0, '{11'd0, 1'b0}},
         '{32'h7FFFFFFE, 1'b1, 1'b0, '{11'd0, 1'b0}},
         '{32'h7FFFFFFF, 1'b0, 1'b0, '{11'd0, 1'b0}},
         '{32'h00000001, 1'b0, 1'b0, '{11'd0, 1'b0}}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         offer_value(dir_rows[i].value, dir_rows[i].first, dir_rows[i].typed, dir_rows[i].exp);
      wait_for_results();

      // Short sequences of mixed shape; a few continue without the first flag
      for (seq = 0; seq < 40; seq++) begin
         run_len = $urandom_range(1, 14);
         kind    = $urandom_range(0, 4);
         no_idle = (seq % 8 == 5);
         cur     = $urandom;
         if (seq == 12) hold_long_req = 1'b1;
         if (seq == 26) wait_for_results();
         for (n = 0; n < run_len; n++) begin
            case (kind)
               0: v = $urandom;
               1: v = $urandom_range(0, 15) - 32'd8;
               2: begin
                  cur = cur + int'($urandom_range(0, 40)) - 5;
                  v   = cur;
               end
               3: begin
                  cur = cur - int'($urandom_range(0, 40)) + 5;
                  v   = cur;
               end
               default: v = $urandom;
            endcase
            if (kind == 4) f = ($urandom_range(0, 3) == 0);
            else f = (n == 0) && ($urandom_range(0, 9) != 0);
            offer_value(v, f, 1'b0, '0);
         end
      end
      no_idle = 1'b0;
      wait_for_results();

      // Long run: mostly appends with some replacements until the store is full
      cur = int'(32'h80000000) + 5000 + int'($urandom_range(0, 1000));
      offer_value(cur, 1'b1, 1'b0, '0);
      items_in_run = 1;
      while (seq_len < MAX_LEN) begin
         if (items_in_run == 50) hold_long_req = 1'b1;
         no_idle = (seq_len >= 300 && seq_len < 450);
         if ($urandom_range(0, 9) == 0) begin
            v = cur - int'($urandom_range(0, 3000));
         end else begin
            cur = cur + int'($urandom_range(1, 1 << 21));
            v   = cur;
         end
         offer_value(v, 1'b0, 1'b0, '0);
         items_in_run++;
      end
      no_idle = 1'b0;

      // Store full: dropped appends, replacements and equal values at MAX_LEN
      for (n = 0; n < 16; n++) begin
         case (n % 4)
            0: begin
               cur = cur + int'($urandom_range(1, 1000));
               v   = cur;
            end
            1: v = cur - int'($urandom_range(1 << 22, 1 << 24));
            2: v = 32'h7FFFFFFF;
            default: v = tail_store[MAX_LEN - 1];
         endcase
         offer_value(v, 1'b0, 1'b0, '0);
      end
      offer_value(32'h7FFFFFFF, 1'b1, 1'b1, '{11'd1, 1'b0});
      for (n = 0; n < 8; n++) offer_value($urandom, 1'b0, 1'b0, '0);

      wait_for_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_lis_length_tails_search: PASS");
      end else begin
         $display("tb_lis_length_tails_search: FAIL");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #3_000_000;
      $display("tb_lis_length_tails_search: FAIL");
      $finish;
   end

endmodule

// File: filelist.f
rtl/lts_pkg.sv
rtl/lts_ctrl.sv
rtl/lts_dp.sv
rtl/lis_length_tails_search.sv
test/tb_lis_length_tails_search.sv
